// File: sv/ldbad_pkg.sv
// Shared types, constants and context-adaptation functions of the log-domain decoder.
`timescale 1ns / 1ps
package ldbad_pkg;

  localparam int WINDOW_BITS = 32;
  localparam int POS_W       = 6;
  localparam int VT_W        = 18;

  localparam logic [2:0] FUNC_INIT     = 3'd0;
  localparam logic [2:0] FUNC_CTX      = 3'd1;
  localparam logic [2:0] FUNC_WEIGHTED = 3'd2;
  localparam logic [2:0] FUNC_BYPASS   = 3'd3;
  localparam logic [2:0] FUNC_STUFF    = 3'd4;

  localparam logic [9:0] LG_MAX    = 10'd1023;
  localparam logic [9:0] LG_BYPASS = 10'd1023;
  localparam logic [9:0] LG_STUFF  = 10'd4;

  typedef struct packed {
    logic [2:0]             func;
    logic [8:0]             ctx_first;
    logic [8:0]             ctx_second;
    logic [WINDOW_BITS-1:0] stream_window;
  } in_item_t;

  typedef struct packed {
    logic             bin_value;
    logic [POS_W-1:0] bits_used;
    logic             window_overrun;
  } out_item_t;

  typedef struct packed {
    logic       mps;
    logic [1:0] cyc;
    logic [9:0] lg;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{mps: 1'b0, cyc: 2'd0, lg: LG_MAX};

  // bit-unit control
  typedef struct packed {
    logic load;
    logic take;
    logic flag_over;
  } bit_ctrl_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_INIT_FILL, ST_LEAD, ST_RD1, ST_RD2, ST_PREP,
    ST_DECIDE, ST_RENORM, ST_UPD1, ST_RD2B, ST_UPD2, ST_DONE
  } state_e;

  function automatic logic [7:0] lps_step(input logic [2:0] cwr);
    case (cwr)
      3'd3:    lps_step = 8'd197;
      3'd4:    lps_step = 8'd95;
      default: lps_step = 8'd46;
    endcase
  endfunction

  function automatic ctx_t adapt(input ctx_t c, input logic bin);
    logic [2:0]  cwr;
    logic [1:0]  cyc;
    logic        mps;
    logic [10:0] lg;
    cwr = (c.cyc <= 2'd1) ? 3'd3 : ((c.cyc == 2'd2) ? 3'd4 : 3'd5);
    cyc = c.cyc;
    mps = c.mps;
    if (bin != c.mps) begin
      cyc = (c.cyc < 2'd3) ? c.cyc + 2'd1 : 2'd3;
    end else if (c.cyc == 2'd0) begin
      cyc = 2'd1;
    end
    if (bin == c.mps) begin
      lg = {1'b0, c.lg} - ({1'b0, c.lg} >> cwr) - ({1'b0, c.lg} >> (cwr + 3'd2));
    end else begin
      lg = {1'b0, c.lg} + {3'b0, lps_step(cwr)};
      if (lg > 11'd1023) begin
        lg  = 11'd2047 - lg;
        mps = ~mps;
      end
    end
    adapt = '{mps: mps, cyc: cyc, lg: lg[9:0]};
  endfunction

endpackage

// File: sv/ldbad_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ldbad_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: sv/ldbad_bit_unit.sv
// Stream window shifter: hands out one bit per take, tracks bits used and overrun.
`timescale 1ns / 1ps
module ldbad_bit_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ldbad_pkg::bit_ctrl_t               ctrl_i,
  input  logic [ldbad_pkg::WINDOW_BITS-1:0]  window_i,
  output logic                               bit_o,
  output logic                               empty_o,
  output logic [ldbad_pkg::POS_W-1:0]        pos_o,
  output logic                               over_o
);
  logic [ldbad_pkg::WINDOW_BITS-1:0] win_q, win_d;
  logic [ldbad_pkg::POS_W-1:0]       pos_q, pos_d;
  logic                              over_q, over_d;

  assign empty_o = (pos_q >= ldbad_pkg::POS_W'(ldbad_pkg::WINDOW_BITS));
  assign bit_o   = empty_o ? 1'b0 : win_q[ldbad_pkg::WINDOW_BITS-1];
  assign pos_o   = pos_q;
  assign over_o  = over_q;

  always_comb begin
    win_d  = win_q;
    pos_d  = pos_q;
    over_d = over_q;
    if (ctrl_i.load) begin
      win_d  = window_i;
      pos_d  = '0;
      over_d = 1'b0;
    end else if (ctrl_i.take) begin
      if (empty_o) begin
        over_d = 1'b1;
      end else begin
        win_d = {win_q[ldbad_pkg::WINDOW_BITS-2:0], 1'b0};
        pos_d = pos_q + 1'b1;
      end
    end else if (ctrl_i.flag_over) begin
      over_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      over_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      over_q <= over_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end
endmodule

// File: sv/log_domain_binary_arith_decoder.sv
// Top level: log-domain adaptive binary arithmetic decoder with context store and sequencer.
`timescale 1ns / 1ps
// Flow: bypass/stuffing bins go straight to the decision; context bins read one context and
//   write it back, weighted bins two; an LPS adds renormalization and leading-one shifts.
// Init: the value-register fill, the leading-one search, then a sweep over all contexts.
// Throughput: one item at a time; a stalled result holds the next item off.
// Reset: asynchronous, active low; afterwards a clearing pass runs
//   over the context RAM before the first item is accepted.
module log_domain_binary_arith_decoder #(
  parameter int CONTEXTS = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ldbad_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ldbad_pkg::out_item_t out_item_o
);
  localparam int AW = $clog2(CONTEXTS);
  localparam int VW = ldbad_pkg::VT_W;

  ldbad_pkg::state_e state_q, state_d;

  // architectural registers
  logic [5:0] re_q, re_d;
  logic [7:0] rm_q, rm_d;
  logic [5:0] ve_q, ve_d;
  logic [7:0] vm_q, vm_d;

  // per-item working registers
  logic [2:0]    func_q, func_d;
  logic [AW-1:0] c1_q, c1_d, c2_q, c2_d;
  ldbad_pkg::ctx_t e1_q, e1_d, e2_q, e2_d;
  logic          pm_q, pm_d;
  logic [9:0]    lg_q, lg_d;
  logic          bin_q, bin_d;
  logic [8:0]    rl_q, rl_d;
  logic [VW-1:0] vt_q, vt_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          clr_init_q, clr_init_d;

  ldbad_pkg::out_item_t out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  // bit unit
  ldbad_pkg::bit_ctrl_t bctl;
  logic                 tbit, tempty, tover;
  logic [ldbad_pkg::POS_W-1:0] tpos;

  // RAM
  logic            ram_we;
  logic [AW-1:0]   ram_wa, ram_ra;
  ldbad_pkg::ctx_t ram_wd, ram_rd;

  logic in_acc;
  logic out_free;

  assign in_acc   = in_valid_i && (state_q == ldbad_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // context index modulo CONTEXTS (indices stay below twice CONTEXTS)
  function automatic logic [AW-1:0] ctx_idx(input logic [8:0] c);
    logic [10:0] ce;
    logic [10:0] cr;
    ce = {2'b0, c};
    cr = (ce >= 11'(CONTEXTS)) ? ce - 11'(CONTEXTS) : ce;
    ctx_idx = cr[AW-1:0];
  endfunction

  ldbad_bit_unit u_bits (
    .clk_i,
    .rst_ni,
    .ctrl_i   (bctl),
    .window_i (in_item_i.stream_window),
    .bit_o    (tbit),
    .empty_o  (tempty),
    .pos_o    (tpos),
    .over_o   (tover)
  );

  ldbad_ram #(.WIDTH($bits(ldbad_pkg::ctx_t)), .DEPTH(CONTEXTS)) u_ctx_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  // decision datapath (one subtract/compare set)
  logic [7:0] q;
  logic       ge;
  logic [6:0] rs2;
  logic [8:0] rt2_w;
  logic [7:0] rt2;
  logic       same_e;
  logic       lps;
  logic [8:0] rl_new;
  logic [VW-1:0] vt_lps;

  always_comb begin
    q      = lg_q[9:2];
    ge     = (rm_q >= q);
    rs2    = {1'b0, re_q} + (ge ? 7'd0 : 7'd1);
    rt2_w  = ge ? ({1'b0, rm_q} - {1'b0, q}) : (9'd256 + {1'b0, rm_q} - {1'b0, q});
    rt2    = rt2_w[7:0];
    same_e = (rs2 == {1'b0, ve_q});
    lps    = (rs2 > {1'b0, ve_q}) || (same_e && (vm_q >= rt2));
    rl_new = {1'b0, q} + (ge ? 9'd0 : {1'b0, rm_q});
    vt_lps = same_e ? VW'(vm_q - rt2)
                    : VW'(11'd256 + {2'b0, vm_q, tbit} - {3'b0, rt2});
  end

  // weighted probability
  logic [10:0] lsum;
  logic [9:0]  ldiff;
  always_comb begin
    lsum  = {1'b0, e1_q.lg} + {1'b0, e2_q.lg};
    ldiff = (e1_q.lg < e2_q.lg) ? (e2_q.lg - e1_q.lg) : (e1_q.lg - e2_q.lg);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ldbad_pkg::ST_CLEAR: begin
        if (clr_q == AW'(CONTEXTS - 1)) begin
          state_d = clr_init_q ? ldbad_pkg::ST_DONE : ldbad_pkg::ST_IDLE;
        end
      end
      ldbad_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_item_i.func)
            ldbad_pkg::FUNC_INIT:     state_d = ldbad_pkg::ST_INIT_FILL;
            ldbad_pkg::FUNC_CTX,
            ldbad_pkg::FUNC_WEIGHTED: state_d = ldbad_pkg::ST_RD1;
            ldbad_pkg::FUNC_BYPASS,
            ldbad_pkg::FUNC_STUFF:    state_d = ldbad_pkg::ST_PREP;
            default:                  state_d = ldbad_pkg::ST_DONE;
          endcase
        end
      end
      ldbad_pkg::ST_INIT_FILL: begin
        if (cnt_q == 4'd1) state_d = ldbad_pkg::ST_LEAD;
      end
      ldbad_pkg::ST_RD1: begin
        state_d = (func_q == ldbad_pkg::FUNC_WEIGHTED) ? ldbad_pkg::ST_RD2
                                                       : ldbad_pkg::ST_PREP;
      end
      ldbad_pkg::ST_RD2:  state_d = ldbad_pkg::ST_PREP;
      ldbad_pkg::ST_PREP: state_d = ldbad_pkg::ST_DECIDE;
      ldbad_pkg::ST_DECIDE: begin
        if (lps) begin
          state_d = ldbad_pkg::ST_RENORM;
        end else if (func_q == ldbad_pkg::FUNC_CTX || func_q == ldbad_pkg::FUNC_WEIGHTED) begin
          state_d = ldbad_pkg::ST_UPD1;
        end else begin
          state_d = ldbad_pkg::ST_DONE;
        end
      end
      ldbad_pkg::ST_RENORM: begin
        if (rl_q == 9'd0 || rl_q >= 9'h100) state_d = ldbad_pkg::ST_LEAD;
      end
      ldbad_pkg::ST_LEAD: begin
        if (vt_q >= VW'(9'h100) || tempty) begin
          if (func_q == ldbad_pkg::FUNC_INIT) begin
            state_d = ldbad_pkg::ST_CLEAR;
          end else if (func_q == ldbad_pkg::FUNC_CTX ||
                       func_q == ldbad_pkg::FUNC_WEIGHTED) begin
            state_d = ldbad_pkg::ST_UPD1;
          end else begin
            state_d = ldbad_pkg::ST_DONE;
          end
        end
      end
      ldbad_pkg::ST_UPD1: begin
        state_d = (func_q == ldbad_pkg::FUNC_WEIGHTED) ? ldbad_pkg::ST_RD2B
                                                       : ldbad_pkg::ST_DONE;
      end
      ldbad_pkg::ST_RD2B: state_d = ldbad_pkg::ST_UPD2;
      ldbad_pkg::ST_UPD2: state_d = ldbad_pkg::ST_DONE;
      ldbad_pkg::ST_DONE: begin
        if (out_free) state_d = ldbad_pkg::ST_IDLE;
      end
      default: state_d = ldbad_pkg::ST_CLEAR;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    re_d = re_q; rm_d = rm_q; ve_d = ve_q; vm_d = vm_q;
    func_d = func_q; c1_d = c1_q; c2_d = c2_q;
    e1_d = e1_q; e2_d = e2_q; pm_d = pm_q; lg_d = lg_q; bin_d = bin_q;
    rl_d = rl_q; vt_d = vt_q; cnt_d = cnt_q; clr_d = clr_q; clr_init_d = clr_init_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    bctl   = '0;
    ram_we = 1'b0;
    ram_wa = c1_q;
    ram_wd = ldbad_pkg::CTX_RESET;
    ram_ra = c2_q;

    case (state_q)
      ldbad_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_q;
        ram_wd = ldbad_pkg::CTX_RESET;
        clr_d  = clr_q + 1'b1;
      end
      ldbad_pkg::ST_IDLE: begin
        ram_ra = ctx_idx(in_item_i.ctx_first);
        if (in_acc) begin
          bctl.load = 1'b1;
          func_d    = in_item_i.func;
          c1_d      = ctx_idx(in_item_i.ctx_first);
          c2_d      = ctx_idx(in_item_i.ctx_second);
          bin_d     = 1'b0;
          cnt_d     = 4'd9;
          vt_d      = '0;
          if (in_item_i.func == ldbad_pkg::FUNC_INIT) begin
            re_d = 6'd0;
            rm_d = 8'd255;
          end
        end
      end
      ldbad_pkg::ST_INIT_FILL: begin
        bctl.take = 1'b1;
        vt_d  = {vt_q[VW-2:0], tbit};
        cnt_d = cnt_q - 1'b1;
        ve_d  = 6'd0;
      end
      ldbad_pkg::ST_RD1: begin
        ram_ra = c2_q;
        e1_d   = ram_rd;
      end
      ldbad_pkg::ST_RD2: begin
        e2_d = ram_rd;
      end
      ldbad_pkg::ST_PREP: begin
        case (func_q)
          ldbad_pkg::FUNC_CTX: begin
            pm_d = e1_q.mps;
            lg_d = e1_q.lg;
          end
          ldbad_pkg::FUNC_WEIGHTED: begin
            pm_d = e1_q.mps;
            lg_d = lsum[10:1];
            if (e1_q.mps != e2_q.mps) begin
              pm_d = (e1_q.lg < e2_q.lg) ? e1_q.mps : e2_q.mps;
              lg_d = ldbad_pkg::LG_MAX - {1'b0, ldiff[9:1]};
            end
          end
          ldbad_pkg::FUNC_STUFF: begin
            pm_d = 1'b0;
            lg_d = ldbad_pkg::LG_STUFF;
          end
          default: begin
            pm_d = 1'b0;
            lg_d = ldbad_pkg::LG_BYPASS;
          end
        endcase
      end
      ldbad_pkg::ST_DECIDE: begin
        if (lps) begin
          bin_d     = ~pm_q;
          re_d      = 6'd0;
          rl_d      = rl_new;
          vt_d      = vt_lps;
          bctl.take = !same_e;
        end else begin
          bin_d = pm_q;
          re_d  = rs2[5:0];
          rm_d  = rt2;
        end
      end
      ldbad_pkg::ST_RENORM: begin
        if (rl_q != 9'd0 && rl_q < 9'h100) begin
          bctl.take = 1'b1;
          rl_d = {rl_q[7:0], 1'b0};
          vt_d = {vt_q[VW-2:0], tbit};
        end else begin
          rm_d = rl_q[7:0];
          ve_d = 6'd0;
        end
      end
      ldbad_pkg::ST_LEAD: begin
        if (vt_q < VW'(9'h100)) begin
          if (tempty) begin
            bctl.flag_over = 1'b1;
            vm_d = vt_q[7:0];
          end else begin
            bctl.take = 1'b1;
            vt_d = {vt_q[VW-2:0], tbit};
            if (ve_q < 6'd63) ve_d = ve_q + 1'b1;
          end
        end else begin
          vm_d = vt_q[7:0];
        end
        clr_d      = '0;
        clr_init_d = 1'b1;
      end
      ldbad_pkg::ST_UPD1: begin
        ram_we = 1'b1;
        ram_wa = c1_q;
        ram_wd = ldbad_pkg::adapt(e1_q, bin_q);
      end
      ldbad_pkg::ST_RD2B: begin
        ram_ra = c2_q;
      end
      ldbad_pkg::ST_UPD2: begin
        ram_we = 1'b1;
        ram_wa = c2_q;
        ram_wd = ldbad_pkg::adapt(ram_rd, bin_q);
      end
      ldbad_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.bin_value    = bin_q;
          out_d.bits_used    = tpos;
          out_d.window_overrun = tover;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ldbad_pkg::ST_CLEAR;
      re_q        <= 6'd0;
      rm_q        <= 8'd255;
      ve_q        <= 6'd0;
      vm_q        <= 8'd0;
      clr_q       <= '0;
      clr_init_q  <= 1'b0;
      out_valid_q <= 1'b0;
      func_q      <= ldbad_pkg::FUNC_INIT;
      cnt_q       <= 4'd0;
    end else begin
      state_q     <= state_d;
      re_q        <= re_d;
      rm_q        <= rm_d;
      ve_q        <= ve_d;
      vm_q        <= vm_d;
      clr_q       <= clr_d;
      clr_init_q  <= clr_init_d;
      out_valid_q <= out_valid_d;
      func_q      <= func_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q  <= c1_d;
    c2_q  <= c2_d;
    e1_q  <= e1_d;
    e2_q  <= e2_d;
    pm_q  <= pm_d;
    lg_q  <= lg_d;
    bin_q <= bin_d;
    rl_q  <= rl_d;
    vt_q  <= vt_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != ldbad_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
endmodule

// File: tb/log_domain_binary_arith_decoder_tb.sv
// Testbench for the log-domain binary arithmetic decoder: directed rows, then random bins.
`timescale 1ns / 1ps
module log_domain_binary_arith_decoder_tb;

  localparam int NUM_CTX    = 512;
  localparam int RAND_ITEMS = 1750;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  ldbad_pkg::in_item_t  in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  ldbad_pkg::out_item_t out_item_o;

  log_domain_binary_arith_decoder #(.CONTEXTS(NUM_CTX)) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: context store plus range and offset registers.
  logic       mdl_mps [NUM_CTX];
  logic [1:0] mdl_cyc [NUM_CTX];
  logic [9:0] mdl_lg  [NUM_CTX];
  int unsigned rng_exp, rng_man, val_exp, val_man;
  logic [31:0] win;
  int unsigned win_pos;
  bit          win_over;

  ldbad_pkg::out_item_t expected_q[$];
  int        err_cnt = 0;
  bit        stim_done = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch %s got %0d want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic void clear_store();
    for (int i = 0; i < NUM_CTX; i++) begin
      mdl_mps[i] = 1'b0;
      mdl_cyc[i] = 2'd0;
      mdl_lg[i]  = ldbad_pkg::LG_MAX;
    end
  endfunction

  function automatic int unsigned next_bit();
    if (win_pos >= 32) begin
      win_over = 1'b1;
      return 0;
    end
    next_bit = win[31 - win_pos];
    win_pos++;
  endfunction

  // Shift stream bits in until bit 8 is set or the window runs out; exponent saturates at 63.
  function automatic int unsigned leading_one(inout int unsigned vt);
    int unsigned e;
    e = 0;
    while (vt < 32'h100) begin
      if (win_pos >= 32) begin
        win_over = 1'b1;
        break;
      end
      vt = (vt << 1) | next_bit();
      if (e < 63) e++;
    end
    return e;
  endfunction

  function automatic logic decide_bin(input logic pmps, input int unsigned lg);
    int unsigned q, rs2, rt2, rl, vt;
    bit sflag;
    q = lg >> 2;
    if (rng_man >= q) begin
      rs2 = rng_exp; rt2 = rng_man - q; sflag = 0;
    end else begin
      rs2 = rng_exp + 1; rt2 = 256 + rng_man - q; sflag = 1;
    end
    if (rs2 > val_exp || (rs2 == val_exp && val_man >= rt2)) begin
      rl = q + (sflag ? rng_man : 0);
      if (rs2 == val_exp) vt = val_man - rt2;
      else vt = 256 + ((val_man << 1) | next_bit()) - rt2;
      if (rl != 0) begin
        while (rl < 32'h100) begin
          rl = rl << 1;
          vt = (vt << 1) | next_bit();
        end
      end
      rng_exp = 0;
      rng_man = rl & 8'hFF;
      val_exp = leading_one(vt);
      val_man = vt & 8'hFF;
      return ~pmps;
    end
    rng_exp = rs2 & 6'h3F;
    rng_man = rt2 & 8'hFF;
    return pmps;
  endfunction

  function automatic void adapt_ctx(input logic bin, input int k);
    int unsigned cyc, lg, cwr, stp;
    logic mps;
    cyc = mdl_cyc[k]; mps = mdl_mps[k]; lg = mdl_lg[k];
    cwr = (cyc <= 1) ? 3 : (cyc == 2 ? 4 : 5);
    stp = (cwr == 3) ? 197 : (cwr == 4 ? 95 : 46);
    if (bin != mps) cyc = (cyc < 3) ? cyc + 1 : 3;
    else if (cyc == 0) cyc = 1;
    if (bin == mps) lg = lg - (lg >> cwr) - (lg >> (cwr + 2));
    else begin
      lg += stp;
      if (lg > 1023) begin
        lg = 2047 - lg;
        mps = ~mps;
      end
    end
    mdl_cyc[k] = cyc[1:0]; mdl_mps[k] = mps; mdl_lg[k] = lg[9:0];
  endfunction

  function automatic ldbad_pkg::out_item_t decode_item(input ldbad_pkg::in_item_t it);
    ldbad_pkg::out_item_t r;
    int unsigned c1, c2, l1, l2, lg, vt;
    logic pm, bin;
    c1 = it.ctx_first % NUM_CTX;
    c2 = it.ctx_second % NUM_CTX;
    win = it.stream_window; win_pos = 0; win_over = 0; bin = 1'b0;
    case (it.func)
      ldbad_pkg::FUNC_INIT: begin
        clear_store();
        rng_exp = 0; rng_man = 255; vt = 0;
        for (int i = 0; i < 9; i++) vt = (vt << 1) | next_bit();
        val_exp = leading_one(vt);
        val_man = vt & 8'hFF;
      end
      ldbad_pkg::FUNC_CTX: begin
        bin = decide_bin(mdl_mps[c1], mdl_lg[c1]);
        adapt_ctx(bin, c1);
      end
      ldbad_pkg::FUNC_WEIGHTED: begin
        l1 = mdl_lg[c1]; l2 = mdl_lg[c2];
        pm = mdl_mps[c1]; lg = (l1 + l2) >> 1;
        if (mdl_mps[c1] != mdl_mps[c2]) begin
          if (l1 < l2) lg = 1023 - ((l2 - l1) >> 1);
          else begin
            pm = mdl_mps[c2]; lg = 1023 - ((l1 - l2) >> 1);
          end
        end
        bin = decide_bin(pm, lg);
        adapt_ctx(bin, c1);
        adapt_ctx(bin, c2);
      end
      ldbad_pkg::FUNC_BYPASS: bin = decide_bin(1'b0, ldbad_pkg::LG_BYPASS);
      ldbad_pkg::FUNC_STUFF:  bin = decide_bin(1'b0, ldbad_pkg::LG_STUFF);
      default: ;
    endcase
    r.bin_value = bin;
    r.bits_used = win_pos[5:0];
    r.window_overrun = win_over;
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Called at a falling edge; valid stays high straight into the next item when there is no gap.
  task automatic send_item(input ldbad_pkg::in_item_t it, input bit has_fixed,
                           input ldbad_pkg::out_item_t fixed);
    ldbad_pkg::out_item_t pred;
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = decode_item(it);
    // Directed rows with a typed-in answer must also agree with the predictor.
    if (has_fixed && pred != fixed) report_mismatch("directed table row", pred, fixed);
    expected_q.push_back(has_fixed ? fixed : pred);
    @(negedge clk_i);
  endtask

  typedef struct {
    ldbad_pkg::in_item_t  it;
    bit                   has_fixed;
    ldbad_pkg::out_item_t fixed;
  } dir_row_t;

  function automatic ldbad_pkg::in_item_t mk(input logic [2:0] f, input logic [8:0] a,
                                             input logic [8:0] b, input logic [31:0] w);
    ldbad_pkg::in_item_t it;
    it.func = f; it.ctx_first = a; it.ctx_second = b; it.stream_window = w;
    return it;
  endfunction

  function automatic ldbad_pkg::out_item_t res(input logic b, input logic [5:0] n,
                                               input logic o);
    ldbad_pkg::out_item_t r;
    r.bin_value = b; r.bits_used = n; r.window_overrun = o;
    return r;
  endfunction

  // A random request, now and then with an unknown mode; init now and then restarts the stream.
  function automatic ldbad_pkg::in_item_t rand_item(input int hot_ctx);
    int p;
    logic [2:0] f;
    logic [8:0] a, b;
    p = $urandom_range(99);
    if (p < 3) f = ldbad_pkg::FUNC_INIT;
    else if (p < 50) f = ldbad_pkg::FUNC_CTX;
    else if (p < 75) f = ldbad_pkg::FUNC_WEIGHTED;
    else if (p < 88) f = ldbad_pkg::FUNC_BYPASS;
    else if (p < 96) f = ldbad_pkg::FUNC_STUFF;
    else f = $urandom_range(7, 5);
    // Hot contexts adapt far; the rest spread over the whole store.
    a = ($urandom_range(3) != 0) ? 9'(hot_ctx + $urandom_range(3)) : 9'($urandom);
    b = ($urandom_range(7) == 0) ? a : 9'($urandom_range(3) != 0 ? hot_ctx + 4 : $urandom);
    if (f == ldbad_pkg::FUNC_INIT && $urandom_range(1))
      return mk(f, a, b, $urandom & 32'h01FF_FFFF);
    return mk(f, a, b, $urandom_range(9) == 0 ? 32'(0) : $urandom);
  endfunction

  // Stimulus
  initial begin
    dir_row_t rows[$];
    int hot;
    rows = '{
      '{mk(3'd5, 9'd0, 9'd0, 32'hFFFF_FFFF), 1'b1, res(1'b0, 6'd0, 1'b0)},
      '{mk(3'd7, 9'h1FF, 9'h1FF, 32'h0), 1'b1, res(1'b0, 6'd0, 1'b0)},
      '{mk(ldbad_pkg::FUNC_INIT, 9'd0, 9'd0, 32'hFFFF_FFFF), 1'b1, res(1'b0, 6'd9, 1'b0)},
      '{mk(ldbad_pkg::FUNC_CTX, 9'd0, 9'd0, 32'h0), 1'b0, res(0, 0, 0)},
      '{mk(ldbad_pkg::FUNC_CTX, 9'h1FF, 9'd0, 32'hFFFF_FFFF), 1'b0, res(0, 0, 0)},
      '{mk(ldbad_pkg::FUNC_WEIGHTED, 9'd3, 9'd3, 32'hAAAA_5555), 1'b0, res(0, 0, 0)},
      '{mk(ldbad_pkg::FUNC_WEIGHTED, 9'd0, 9'h1FF, 32'h5555_AAAA), 1'b0, res(0, 0, 0)},
      '{mk(ldbad_pkg::FUNC_BYPASS, 9'd0, 9'd0, 32'h8000_0001), 1'b0, res(0, 0, 0)},
      '{mk(ldbad_pkg::FUNC_STUFF, 9'd0, 9'd0, 32'hFFFF_FFFF), 1'b0, res(0, 0, 0)},
      '{mk(ldbad_pkg::FUNC_STUFF, 9'd0, 9'd0, 32'h0), 1'b0, res(0, 0, 0)},
      '{mk(3'd6, 9'd5, 9'd5, 32'h1234_5678), 1'b1, res(1'b0, 6'd0, 1'b0)},
      // Init on an all-zero window: leading-one search runs off the window end.
      '{mk(ldbad_pkg::FUNC_INIT, 9'd0, 9'd0, 32'h0), 1'b1, res(1'b0, 6'd32, 1'b1)},
      '{mk(ldbad_pkg::FUNC_CTX, 9'd7, 9'd0, 32'h0), 1'b0, res(0, 0, 0)},
      '{mk(ldbad_pkg::FUNC_BYPASS, 9'd0, 9'd0, 32'h0), 1'b0, res(0, 0, 0)},
      '{mk(ldbad_pkg::FUNC_WEIGHTED, 9'd7, 9'd8, 32'h0), 1'b0, res(0, 0, 0)},
      // Ninth bit is the only one: eight more bits to bring it up to bit 8.
      '{mk(ldbad_pkg::FUNC_INIT, 9'd0, 9'd0, 32'h0080_0000), 1'b1, res(1'b0, 6'd17, 1'b0)},
      '{mk(ldbad_pkg::FUNC_STUFF, 9'd1, 9'd2, 32'h0000_0001), 1'b0, res(0, 0, 0)},
      '{mk(ldbad_pkg::FUNC_CTX, 9'd1, 9'd1, 32'hF0F0_F0F0), 1'b0, res(0, 0, 0)}
    };
    clear_store();
    rng_exp = 0; rng_man = 255; val_exp = 0; val_man = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) send_item(rows[i].it, rows[i].has_fixed, rows[i].fixed);
    send_item(mk(ldbad_pkg::FUNC_INIT, 9'd0, 9'd0, $urandom), 1'b0, res(0, 0, 0));
    hot = $urandom_range(500);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 200 == 0) hot = $urandom_range(500);
      send_item(rand_item(hot), 1'b0, res(0, 0, 0));
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stall pattern, driven off the falling edge.
  initial begin
    int g;
    @(negedge clk_i);
    forever begin
      g = gap_len();
      if (g != 0) begin
        out_stall_i <= 1'b1;
        repeat (g) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(12, 1)) @(negedge clk_i);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    ldbad_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_item_o, -1);
      end else begin
        want = expected_q.pop_front();
        if (out_item_o.bin_value !== want.bin_value)
          report_mismatch("bin_value", out_item_o.bin_value, want.bin_value);
        if (out_item_o.bits_used !== want.bits_used)
          report_mismatch("bits_used", out_item_o.bits_used, want.bits_used);
        if (out_item_o.window_overrun !== want.window_overrun)
          report_mismatch("window_overrun", out_item_o.window_overrun, want.window_overrun);
      end
    end
  end

  // End of run: drain, settle, then verdict.
  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
